// ----- design/plti_pkg.sv -----
// ---------------------------------------------------------------------------
// plti_pkg
// Shared types, constants and codes of the piecewise-linear table interpolator.
// ---------------------------------------------------------------------------
package plti_pkg;

	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 16;

	localparam int XW     = 32;                  // width of x, y, value, slope
	localparam int DW     = XW + 1;              // width of differences
	localparam int AW     = $clog2(MAX_POINTS);  // table address width
	localparam int PCW    = 7;                   // point_count register width
	localparam int NUM_W  = DW + FRAC_BITS;      // divider dividend width
	localparam int CNT_W  = $clog2(NUM_W);       // divider step counter width
	localparam int LO_W   = DW / 2;              // low slice of multiplier operand
	localparam int HI_W   = DW - LO_W;           // high slice of multiplier operand
	localparam int PROD_W = DW + XW;             // full product width
	localparam int M_W    = PROD_W - FRAC_BITS;  // product after the fraction shift
	localparam int MC_W   = DW + 1;              // clamped product magnitude width
	localparam int S_W    = MC_W + 2;            // final sum width

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_VALUE  = 2'd1;
	localparam logic [1:0] FUNC_SLOPE  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic CFG_POINT_COUNT  = 1'b0;
	localparam logic CFG_COMPLEX_MODE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BELOW     = 3'd1,
		ST_COMPLEX   = 3'd2,
		ST_ZERO_SEG  = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_CHK0,
		S_SRD,
		S_SCK,
		S_DIFF,
		S_DIV,
		S_SLOPE,
		S_MUL0,
		S_MUL1,
		S_SUM,
		S_FIN,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic load;      // write the breakpoint of the current input transfer
		logic start;     // latch query and function
		logic rd_first;  // read table entry 0 instead of the scan index
		logic chk0;      // range and mode checks against entry 0
		logic scan;      // compare scanned entry and advance
		logic diff;      // segment differences, divider setup
		logic div_step;  // one quotient bit
		logic slope;     // sign and clamp of the slope
		logic mul0;      // low partial product
		logic mul1;      // high partial product
		logic sum;       // product sum and clamp
		logic fin;       // final add and clamp
		logic emit;      // move result into the output register
	} cmd_t;

	typedef struct packed {
		logic early_err;
		logic seg_found;
		logic dx_zero;
		logic div_last;
		logic func_slope;
		logic out_full;
	} stat_t;

endpackage

// ----- design/piecewise_linear_table_interp_unit.sv -----
// ---------------------------------------------------------------------------
// piecewise_linear_table_interp_unit
// Breakpoint table with linear interpolation and slope in Q16.16.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_ready  | func, point_index, point_x, point_y, query_x
// out      | out_valid/out_ready  | result_value, status
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a load is written while idle; an evaluation reads entry 0 for the range check,
// scans the table (k breakpoints visited, one memory read each), runs the serial
// divider, then the two partial products, the sum and the final clamp, and hands
// off the result
// errors found by the range check or a zero-width segment finish early
// the output register holds one result; the next item is taken while it waits
// reset clears control and config, the breakpoint table is undefined until loaded
// ---------------------------------------------------------------------------
module piecewise_linear_table_interp_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [plti_pkg::AW-1:0]          point_index,
	input  logic signed [plti_pkg::XW-1:0]   point_x,
	input  logic signed [plti_pkg::XW-1:0]   point_y,
	input  logic signed [plti_pkg::XW-1:0]   query_x,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [plti_pkg::PCW-1:0]         cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [plti_pkg::XW-1:0]   result_value,
	output logic [2:0]                       status
);

	plti_pkg::cmd_t  cmd;
	plti_pkg::stat_t stat;

	plti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plti_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.query_x      (query_x),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.status       (status)
	);

endmodule

// ----- design/plti_ctrl.sv -----
// ---------------------------------------------------------------------------
// plti_ctrl
// Sequencer: breakpoint scan, serial divide, split multiply, result hand-off.
// ---------------------------------------------------------------------------
module plti_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       func,
	output logic             in_ready,
	input  plti_pkg::stat_t  stat,
	output plti_pkg::cmd_t   cmd
);

	plti_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plti_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			plti_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func == plti_pkg::FUNC_LOAD) begin
						cmd.load = 1'b1;
					end else if (func == plti_pkg::FUNC_VALUE || func == plti_pkg::FUNC_SLOPE) begin
						cmd.start = 1'b1;
						state_d   = plti_pkg::S_RD0;
					end
				end
			end
			plti_pkg::S_RD0: begin
				cmd.rd_first = 1'b1;
				state_d      = plti_pkg::S_CHK0;
			end
			plti_pkg::S_CHK0: begin
				cmd.chk0 = 1'b1;
				state_d  = stat.early_err ? plti_pkg::S_DONE : plti_pkg::S_SRD;
			end
			plti_pkg::S_SRD: begin
				state_d = plti_pkg::S_SCK;
			end
			plti_pkg::S_SCK: begin
				cmd.scan = 1'b1;
				state_d  = stat.seg_found ? plti_pkg::S_DIFF : plti_pkg::S_SRD;
			end
			plti_pkg::S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = stat.dx_zero ? plti_pkg::S_DONE : plti_pkg::S_DIV;
			end
			plti_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = plti_pkg::S_SLOPE;
				end
			end
			plti_pkg::S_SLOPE: begin
				cmd.slope = 1'b1;
				state_d   = stat.func_slope ? plti_pkg::S_DONE : plti_pkg::S_MUL0;
			end
			plti_pkg::S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = plti_pkg::S_MUL1;
			end
			plti_pkg::S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = plti_pkg::S_SUM;
			end
			plti_pkg::S_SUM: begin
				cmd.sum = 1'b1;
				state_d = plti_pkg::S_FIN;
			end
			plti_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				state_d = plti_pkg::S_DONE;
			end
			plti_pkg::S_DONE: begin
				if (!stat.out_full) begin
					cmd.emit = 1'b1;
					state_d  = plti_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plti_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/plti_dp.sv -----
// ---------------------------------------------------------------------------
// plti_dp
// Datapath: breakpoint memories, config registers, search, divider,
// multiplier and the output register.
// ---------------------------------------------------------------------------
module plti_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plti_pkg::cmd_t                   cmd,
	output plti_pkg::stat_t                  stat,
	input  logic [1:0]                       func,
	input  logic [plti_pkg::AW-1:0]          point_index,
	input  logic signed [plti_pkg::XW-1:0]   point_x,
	input  logic signed [plti_pkg::XW-1:0]   point_y,
	input  logic signed [plti_pkg::XW-1:0]   query_x,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [plti_pkg::PCW-1:0]         cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [plti_pkg::XW-1:0]   result_value,
	output logic [2:0]                       status
);

	localparam int XW = plti_pkg::XW;
	localparam int DW = plti_pkg::DW;

	logic signed [XW-1:0] mem_x [plti_pkg::MAX_POINTS];
	logic signed [XW-1:0] mem_y [plti_pkg::MAX_POINTS];
	logic signed [XW-1:0] rdx_q, rdy_q;
	logic [plti_pkg::AW-1:0] rd_addr;

	logic [plti_pkg::PCW-1:0] point_count_q;
	logic                     complex_mode_q;
	logic [plti_pkg::AW-1:0]  last;

	logic signed [XW-1:0] q_q;
	logic                 slope_q;
	logic [plti_pkg::AW-1:0] idx_q;
	logic signed [XW-1:0] xl_q, yl_q, xu_q, yu_q;

	logic signed [DW-1:0] dx, dy, dd;
	logic [DW-1:0]        dxmag_q, dmag_q;
	logic                 aneg_q, dneg_q;
	logic [plti_pkg::NUM_W-1:0] dvd_q;
	logic [DW-1:0]              rem_q;
	logic [DW:0]                rem_sh;
	logic                       qbit;
	logic [plti_pkg::CNT_W-1:0] cnt_q;

	logic        sat_pos, sat_neg, sat_q;
	logic [XW-1:0] amag_q;
	logic [plti_pkg::XW+plti_pkg::LO_W-1:0] p0_q;
	logic [plti_pkg::XW+plti_pkg::HI_W-1:0] p1_q;
	logic [plti_pkg::PROD_W-1:0] prod;
	logic [plti_pkg::M_W-1:0]    m;
	logic [plti_pkg::MC_W-1:0]   mc_q;
	logic signed [plti_pkg::S_W-1:0] s;
	logic                        s_ovf;

	logic signed [XW-1:0] res_val_q;
	plti_pkg::status_t    res_st_q;
	logic                 out_valid_q;
	logic signed [XW-1:0] out_val_q;
	plti_pkg::status_t    out_st_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q  <= plti_pkg::PCW'(2);
			complex_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				plti_pkg::CFG_POINT_COUNT:  point_count_q  <= cfg_data;
				plti_pkg::CFG_COMPLEX_MODE: complex_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// last usable index, from the point count clamped between two and the table size
	always_comb begin
		if (point_count_q < plti_pkg::PCW'(2)) begin
			last = plti_pkg::AW'(1);
		end else if (point_count_q > plti_pkg::PCW'(plti_pkg::MAX_POINTS)) begin
			last = plti_pkg::AW'(plti_pkg::MAX_POINTS - 1);
		end else begin
			last = plti_pkg::AW'(point_count_q - plti_pkg::PCW'(1));
		end
	end

	assign rd_addr = cmd.rd_first ? '0 : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_x[point_index] <= point_x;
			mem_y[point_index] <= point_y;
		end
		rdx_q <= mem_x[rd_addr];
		rdy_q <= mem_y[rd_addr];
	end

	// segment search and difference terms
	assign dx = DW'(xu_q) - DW'(xl_q);
	assign dy = DW'(yu_q) - DW'(yl_q);
	assign dd = DW'(q_q) - DW'(xu_q);

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[plti_pkg::NUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, dxmag_q};

	assign sat_pos = !aneg_q && (|dvd_q[plti_pkg::NUM_W-1:XW-1]);
	assign sat_neg = aneg_q && ((|dvd_q[plti_pkg::NUM_W-1:XW])
		|| (dvd_q[XW-1] && (|dvd_q[XW-2:0])));

	assign prod = plti_pkg::PROD_W'(p0_q)
		+ (plti_pkg::PROD_W'(p1_q) << plti_pkg::LO_W);
	assign m    = prod[plti_pkg::PROD_W-1:plti_pkg::FRAC_BITS];

	assign s     = (dneg_q ^ aneg_q) ? (plti_pkg::S_W'(yu_q) - plti_pkg::S_W'(mc_q))
	                                 : (plti_pkg::S_W'(yu_q) + plti_pkg::S_W'(mc_q));
	assign s_ovf = !((&s[plti_pkg::S_W-1:XW-1]) || !(|s[plti_pkg::S_W-1:XW-1]));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q     <= query_x;
			slope_q <= func == plti_pkg::FUNC_SLOPE;
			idx_q   <= plti_pkg::AW'(1);
		end
		if (cmd.chk0) begin
			xl_q <= rdx_q;
			yl_q <= rdy_q;
			if (q_q < rdx_q) begin
				res_val_q <= '0;
				res_st_q  <= plti_pkg::ST_BELOW;
			end else if (complex_mode_q) begin
				res_val_q <= '0;
				res_st_q  <= plti_pkg::ST_COMPLEX;
			end
		end
		if (cmd.scan) begin
			if (stat.seg_found) begin
				xu_q <= rdx_q;
				yu_q <= rdy_q;
			end else begin
				xl_q  <= rdx_q;
				yl_q  <= rdy_q;
				idx_q <= idx_q + plti_pkg::AW'(1);
			end
		end
		if (cmd.diff) begin
			dxmag_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			dvd_q   <= {(dy[DW-1] ? DW'(-dy) : DW'(dy)), plti_pkg::FRAC_BITS'(0)};
			rem_q   <= '0;
			cnt_q   <= '0;
			aneg_q  <= dy[DW-1] ^ dx[DW-1];
			dmag_q  <= dd[DW-1] ? DW'(-dd) : DW'(dd);
			dneg_q  <= dd[DW-1];
			if (dx == '0) begin
				res_val_q <= '0;
				res_st_q  <= plti_pkg::ST_ZERO_SEG;
			end
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? DW'(rem_sh - {1'b0, dxmag_q}) : DW'(rem_sh);
			dvd_q <= {dvd_q[plti_pkg::NUM_W-2:0], qbit};
			cnt_q <= cnt_q + plti_pkg::CNT_W'(1);
		end
		if (cmd.slope) begin
			sat_q <= sat_pos || sat_neg;
			// a negative slope is negated only when it does not clamp; a clamp loads the signed limit
			if (sat_pos) begin
				amag_q    <= {1'b0, {(XW-1){1'b1}}};
				res_val_q <= {1'b0, {(XW-1){1'b1}}};
			end else if (sat_neg) begin
				amag_q    <= {1'b1, {(XW-1){1'b0}}};
				res_val_q <= {1'b1, {(XW-1){1'b0}}};
			end else begin
				amag_q    <= dvd_q[XW-1:0];
				res_val_q <= aneg_q ? -dvd_q[XW-1:0] : dvd_q[XW-1:0];
			end
			res_st_q <= (sat_pos || sat_neg) ? plti_pkg::ST_SATURATED : plti_pkg::ST_OK;
		end
		if (cmd.mul0) begin
			p0_q <= dmag_q[plti_pkg::LO_W-1:0] * amag_q;
		end
		if (cmd.mul1) begin
			p1_q <= dmag_q[DW-1:plti_pkg::LO_W] * amag_q;
		end
		if (cmd.sum) begin
			if (m > plti_pkg::M_W'(1) << DW) begin
				mc_q <= plti_pkg::MC_W'(1) << DW;
			end else begin
				mc_q <= plti_pkg::MC_W'(m);
			end
		end
		if (cmd.fin) begin
			if (s_ovf) begin
				res_val_q <= s[plti_pkg::S_W-1] ? {1'b1, {(XW-1){1'b0}}}
				                                : {1'b0, {(XW-1){1'b1}}};
			end else begin
				res_val_q <= s[XW-1:0];
			end
			res_st_q <= (s_ovf || sat_q) ? plti_pkg::ST_SATURATED : plti_pkg::ST_OK;
		end
		if (cmd.emit) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.early_err  = (q_q < rdx_q) || complex_mode_q;
	assign stat.seg_found  = (rdx_q >= q_q) || (idx_q == last);
	assign stat.dx_zero    = dx == '0;
	assign stat.div_last   = cnt_q == plti_pkg::CNT_W'(plti_pkg::NUM_W - 1);
	assign stat.func_slope = slope_q;
	assign stat.out_full   = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_st_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> idx_q <= last)
		else $error("scan index passed the last breakpoint");

	a_slope_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slope |=> (res_st_q == plti_pkg::ST_OK || res_st_q == plti_pkg::ST_SATURATED))
		else $error("slope stage left an error status");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("output became valid without a result hand-off");

endmodule

// ----- test/tb_piecewise_linear_table_interp_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_piecewise_linear_table_interp_unit
// Loads breakpoint tables and checks every value and slope result against a
// Q16.16 interpolation predictor, under several idle and stall patterns.
// ---------------------------------------------------------------------------
module tb_piecewise_linear_table_interp_unit;

	localparam int STALL_LIMIT  = 6000;
	localparam int SETTLE_TICKS = 300;
	localparam int HOLD_TICKS   = 1500;

	typedef struct {
		logic signed [plti_pkg::XW-1:0] value;
		plti_pkg::status_t              st;
	} interp_result_t;

	class interp_scoreboard;
		logic signed [plti_pkg::XW-1:0] tx [plti_pkg::MAX_POINTS];
		logic signed [plti_pkg::XW-1:0] ty [plti_pkg::MAX_POINTS];
		int unsigned          n_points = 2;
		bit                   cplx     = 0;
		interp_result_t       expected_q [$];
		int                   st_seen [5] = '{0, 0, 0, 0, 0};

		function longint clamp_s32(longint v, ref bit sat);
			if (v > 64'sd2147483647) begin
				sat = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				sat = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function void note_input(logic [1:0] f, logic [plti_pkg::AW-1:0] idx,
				logic signed [plti_pkg::XW-1:0] px, logic signed [plti_pkg::XW-1:0] py,
				logic signed [plti_pkg::XW-1:0] qx);
			interp_result_t r;
			longint q, dx, dy, a, d, s;
			longint unsigned m;
			int unsigned n, up;
			bit sat, neg;
			if (f == plti_pkg::FUNC_LOAD) begin
				tx[idx] = px;
				ty[idx] = py;
				return;
			end
			if (f != plti_pkg::FUNC_VALUE && f != plti_pkg::FUNC_SLOPE)
				return;
			n = n_points < 2 ? 2 : (n_points > plti_pkg::MAX_POINTS ?
				plti_pkg::MAX_POINTS : n_points);
			q = qx;
			r.value = '0;
			r.st = plti_pkg::ST_OK;
			if (q < longint'(tx[0])) begin
				r.st = plti_pkg::ST_BELOW;
			end else if (cplx) begin
				r.st = plti_pkg::ST_COMPLEX;
			end else begin
				up = n - 1;
				for (int i = 1; i < n; i++)
					if (longint'(tx[i]) >= q) begin
						up = i;
						break;
					end
				dx = longint'(tx[up]) - longint'(tx[up-1]);
				dy = longint'(ty[up]) - longint'(ty[up-1]);
				if (dx == 0) begin
					r.st = plti_pkg::ST_ZERO_SEG;
				end else begin
					sat = 0;
					a = clamp_s32((dy <<< plti_pkg::FRAC_BITS) / dx, sat);
					if (f == plti_pkg::FUNC_SLOPE) begin
						r.value = a[plti_pkg::XW-1:0];
					end else begin
						d = q - longint'(tx[up]);
						neg = (d < 0) != (a < 0);
						// magnitudes fit 33 x 32 bits, so the product stays in 64
						m = ((d < 0 ? -d : d) * (a < 0 ? -a : a)) >> plti_pkg::FRAC_BITS;
						if (m > (64'd1 << 33))
							m = 64'd1 << 33;
						s = longint'(ty[up]) + (neg ? -longint'(m) : longint'(m));
						s = clamp_s32(s, sat);
						r.value = s[plti_pkg::XW-1:0];
					end
					if (sat)
						r.st = plti_pkg::ST_SATURATED;
				end
			end
			expected_q.push_back(r);
		endfunction

		function string check(logic signed [plti_pkg::XW-1:0] value, logic [2:0] st);
			interp_result_t e;
			if (expected_q.size() == 0)
				return $sformatf("result %0d status %0d with nothing expected", value, st);
			e = expected_q.pop_front();
			if (st <= plti_pkg::ST_SATURATED)
				st_seen[st]++;
			if (st !== e.st || value !== e.value)
				return $sformatf("got value %0d status %0d, expected value %0d status %0d",
					value, st, e.value, e.st);
			return "";
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [1:0] func;
	logic [plti_pkg::AW-1:0] point_index;
	logic signed [plti_pkg::XW-1:0] point_x, point_y, query_x;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [plti_pkg::PCW-1:0] cfg_data;
	logic out_valid, out_ready;
	logic signed [plti_pkg::XW-1:0] result_value;
	logic [2:0] status;

	interp_scoreboard sb;
	int mismatches = 0;
	int stalled_ticks = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	bit hold_req = 0;
	bit hold_taken = 0;
	int loads_sent = 0;
	int evals_sent = 0;
	int results_seen = 0;

	piecewise_linear_table_interp_unit DUT (.*);

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		func = plti_pkg::FUNC_LOAD;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		query_x = '0;
		cfg_valid = 0;
		cfg_index = plti_pkg::CFG_POINT_COUNT;
		cfg_data = '0;
		out_ready = 0;
	end

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// result side, with a long hold-off counted here when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_req && !hold_taken) begin
			out_ready <= 0;
			hold_taken <= 1;
			hold_left <= HOLD_TICKS - 1;
		end else if (hold_left > 0) begin
			out_ready <= 0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// sample mid-cycle, all inputs and outputs are settled here
	always @(negedge clk) begin
		string msg;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				msg = sb.check(result_value, status);
				if (msg != "")
					report(msg);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
				stalled_ticks <= 0;
			else
				stalled_ticks <= stalled_ticks + 1;
		end
	end

	initial begin
		wait (stalled_ticks >= STALL_LIMIT);
		$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send(logic [1:0] f, logic [plti_pkg::AW-1:0] idx,
			logic signed [plti_pkg::XW-1:0] px, logic signed [plti_pkg::XW-1:0] py,
			logic signed [plti_pkg::XW-1:0] qx);
		bit rdy;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1;
		func <= f;
		point_index <= idx;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		forever begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
			if (rdy)
				break;
		end
		sb.note_input(f, idx, px, py, qx);
		if (f == plti_pkg::FUNC_LOAD)
			loads_sent++;
		else if (f != plti_pkg::FUNC_UNUSED)
			evals_sent++;
	endtask

	task automatic write_reg(logic idx, logic [plti_pkg::PCW-1:0] data);
		bit rdy;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		forever begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
			if (rdy)
				break;
		end
		cfg_valid <= 0;
		if (idx == plti_pkg::CFG_POINT_COUNT)
			sb.n_points = data;
		else
			sb.cplx = data[0];
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	function automatic logic signed [plti_pkg::XW-1:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[plti_pkg::XW-1:0];
	endfunction

	function automatic logic [1:0] pick_eval();
		return $urandom_range(1) ? plti_pkg::FUNC_SLOPE : plti_pkg::FUNC_VALUE;
	endfunction

	// kind 0 sorted, 1 sorted with repeats and wide steps, 2 unsorted
	task automatic refill(int cnt, int kind);
		longint cur;
		logic signed [plti_pkg::XW-1:0] yv;
		cur = longint'($signed($urandom)) >>> $urandom_range(1, 16);
		for (int i = 0; i < cnt; i++) begin
			yv = $urandom_range(1) ? $signed($urandom) : $signed($urandom) >>> 12;
			if (kind == 2)
				send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(i),
					$signed($urandom) >>> $urandom_range(0, 8), yv, '0);
			else
				send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(i), sat32(cur), yv, '0);
			if (!(kind == 1 && $urandom_range(5) == 0))
				cur += $urandom_range(1, 1 << $urandom_range(0, kind == 1 ? 30 : 20));
		end
	endtask

	task automatic random_item(int cnt);
		int r, k;
		longint q;
		r = $urandom_range(99);
		if (r < 6) begin
			send(plti_pkg::FUNC_UNUSED, plti_pkg::AW'($urandom), $signed($urandom),
				$signed($urandom), $signed($urandom));
		end else if (r < 14) begin
			send(plti_pkg::FUNC_LOAD, plti_pkg::AW'($urandom_range(cnt - 1)),
				$signed($urandom), $signed($urandom), $signed($urandom));
		end else if (r < 22) begin
			send(pick_eval(), plti_pkg::AW'($urandom), $signed($urandom),
				$signed($urandom), $signed($urandom));
		end else begin
			k = $urandom_range(cnt - 1);
			q = sb.tx[k];
			case ($urandom_range(2))
				0: ;
				1: q += longint'($urandom_range(1 << 18)) - (1 << 17);
				default: q += longint'($signed($urandom)) >>> $urandom_range(0, 31);
			endcase
			send(pick_eval(), plti_pkg::AW'($urandom), $signed($urandom),
				$signed($urandom), sat32(q));
		end
	endtask

	initial begin
		int counts [8] = '{2, 64, 127, 0, 5, 17, 33, 1};
		int eff;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: four-point table, every function and each flagged case
		write_reg(plti_pkg::CFG_POINT_COUNT, plti_pkg::PCW'(4));
		write_reg(plti_pkg::CFG_COMPLEX_MODE, '0);
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(0), -10 <<< 16, 5 <<< 16, '0);
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(1), 0, 5 <<< 16, '0);
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(2), 10 <<< 16, -15 <<< 16, '0);
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(3), 20 <<< 16, 25 <<< 16, '0);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, -11 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, -10 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, -3 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 0);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 7 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 35 <<< 16);
		send(plti_pkg::FUNC_SLOPE, '0, '0, '0, 5 <<< 16);
		send(plti_pkg::FUNC_SLOPE, '0, '0, '0, 15 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 32'sh7fffffff);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 32'sh80000000);
		send(plti_pkg::FUNC_UNUSED, '1, '1, '1, '1);
		// zero-width last segment
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(3), 10 <<< 16, 25 <<< 16, '0);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 15 <<< 16);
		// steep segment saturates the slope
		send(plti_pkg::FUNC_LOAD, plti_pkg::AW'(3), (10 <<< 16) + 1, 32'sh7fffffff, '0);
		send(plti_pkg::FUNC_SLOPE, '0, '0, '0, 10 <<< 16);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, (10 <<< 16) + 1);
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 9 <<< 16);
		drain();
		write_reg(plti_pkg::CFG_COMPLEX_MODE, plti_pkg::PCW'(1));
		send(plti_pkg::FUNC_VALUE, '0, '0, '0, 3 <<< 16);
		send(plti_pkg::FUNC_SLOPE, '0, '0, '0, -20 <<< 16);
		drain();

		for (int s = 0; s < 8; s++) begin
			case (s % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
				default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
			endcase
			write_reg(plti_pkg::CFG_POINT_COUNT, plti_pkg::PCW'(counts[s]));
			write_reg(plti_pkg::CFG_COMPLEX_MODE, plti_pkg::PCW'(s == 5));
			eff = counts[s] < 2 ? 2 : (counts[s] > plti_pkg::MAX_POINTS ?
				plti_pkg::MAX_POINTS : counts[s]);
			refill(eff, s % 3);
			// output held off while the input keeps offering, so the block backs up
			if (s == 4)
				hold_req = 1;
			for (int i = 0; i < 115; i++)
				random_item(eff);
			drain();
		end

		$display("covered %0d evaluations and %0d loads, %0d results checked",
			evals_sent, loads_sent, results_seen);
		$display("status mix ok/below/complex/zero-width/saturated: %0d/%0d/%0d/%0d/%0d",
			sb.st_seen[0], sb.st_seen[1], sb.st_seen[2], sb.st_seen[3], sb.st_seen[4]);
		if (mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			if (sb.pending() != 0)
				report($sformatf("%0d results never arrived", sb.pending()));
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/plti_pkg.sv
design/plti_ctrl.sv
design/plti_dp.sv
design/piecewise_linear_table_interp_unit.sv
test/tb_piecewise_linear_table_interp_unit.sv
